// ===== hdl/ems_pkg.sv =====
`default_nettype none

package ems_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned CntW  = $clog2(DataW);
  localparam int unsigned CfgAddrW = 2;

  localparam logic [DataW-1:0] GoldenGamma = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [DataW-1:0] MixMulA     = 64'hbf58_476d_1ce4_e5b9;
  localparam logic [DataW-1:0] MixMulB     = 64'h94d0_49bb_1331_11eb;
  localparam logic [DataW-1:0] MixerSeed   = 64'h1234_5678_9abc_def0;

  localparam int unsigned ShiftA = 30;
  localparam int unsigned ShiftB = 27;
  localparam int unsigned ShiftC = 31;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_SLIDE_BASE = 2'd0,
    CFG_SLOT_COUNT = 2'd1,
    CFG_ALIGNMENT  = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_DIV,
    ST_MUL3,
    ST_FIN
  } ems_state_e;

  typedef struct packed {
    logic             func;
    logic [DataW-1:0] timestamp;
    logic [DataW-1:0] hw_random;
    logic             hw_random_ok;
  } ems_in_t;

  typedef struct packed {
    logic [DataW-1:0] random_value;
    logic [DataW-1:0] slide;
  } ems_out_t;

endpackage

`default_nettype wire

// ===== hdl/entropy_mixed_slide_generator.sv =====
`default_nettype none

// Channel  | Dir | Handshake                 | Payload
// ---------+-----+---------------------------+-----------------------------------
// in       | in  | in_valid_i / in_stall_o   | ems_in_t  (func, timestamp, hw word)
// out      | out | out_valid_o / out_stall_i | ems_out_t (random_value, slide)
// cfg      | in  | cfg_valid_i / cfg_ready_o | cfg_addr_i, cfg_data_i
//
// One request at a time. Each serial pass through the shared multiplier or the
// remainder unit takes 64 bit steps, followed by a done strobe.
// Raw request: 2 multiplier passes.
// Slide request: 2 multiplies, 1 remainder, 1 multiply.
// Degenerate slide (alignment or slot count zero): no serial work, state untouched.
// Reset puts the mixer at its seed and clears the config registers.
// in_stall_o stays high while a request is in flight; a finished result waits
// in its own state only while the output register is still held by out_stall_i.
module entropy_mixed_slide_generator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  ems_pkg::ems_in_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output ems_pkg::ems_out_t              out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ems_pkg::CfgAddrW-1:0]   cfg_addr_i,
  input  logic [ems_pkg::DataW-1:0]      cfg_data_i
);
  import ems_pkg::*;

  ems_state_e st_q, st_d;

  // config registers
  logic [DataW-1:0] slide_base_q, slot_count_q, alignment_q;

  // mixer and working registers
  logic [DataW-1:0] mix_q, mix_d;
  logic             func_q, func_d;
  logic [DataW-1:0] rand_q, rand_d;
  logic [DataW-1:0] slide_q, slide_d;

  // output register
  logic     out_valid_q;
  ems_out_t out_q;
  logic     out_load;

  // shared serial units
  logic             mul_start, mul_done;
  logic [DataW-1:0] mul_a, mul_b, mul_prod;
  logic             div_start, div_done;
  logic [DataW-1:0] div_rem;

  logic             in_acc, out_acc, degen;
  logic [DataW-1:0] mixed, z1, z2, zr;

  ems_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  ems_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .dvd_i   (rand_d),
    .dvs_i   (slot_count_q),
    .done_o  (div_done),
    .rem_o   (div_rem)
  );

  assign in_stall_o  = (st_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_q && !out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign degen       = (alignment_q == '0) || (slot_count_q == '0);

  // fold timestamp and optional hw word in, then step by the golden gamma
  assign mixed = (mix_q ^ in_data_i.timestamp
                  ^ (in_data_i.hw_random_ok ? in_data_i.hw_random : '0)) + GoldenGamma;
  assign z1 = mixed ^ (mixed >> ShiftA);
  assign z2 = mul_prod ^ (mul_prod >> ShiftB);
  assign zr = mul_prod ^ (mul_prod >> ShiftC);

  always_comb begin
    st_d      = st_q;
    mix_d     = mix_q;
    func_d    = func_q;
    rand_d    = rand_q;
    slide_d   = slide_q;
    mul_start = 1'b0;
    mul_a     = z1;
    mul_b     = MixMulA;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (st_q)
      ST_IDLE: begin
        if (in_acc) begin
          func_d = in_data_i.func;
          if (in_data_i.func && degen) begin
            rand_d  = '0;
            slide_d = slide_base_q;
            st_d    = ST_FIN;
          end else begin
            mix_d     = mixed;
            mul_start = 1'b1;
            st_d      = ST_MUL1;
          end
        end
      end
      ST_MUL1: begin
        if (mul_done) begin
          mul_a     = z2;
          mul_b     = MixMulB;
          mul_start = 1'b1;
          st_d      = ST_MUL2;
        end
      end
      ST_MUL2: begin
        if (mul_done) begin
          rand_d = zr;
          if (func_q) begin
            div_start = 1'b1;
            st_d      = ST_DIV;
          end else begin
            slide_d = '0;
            st_d    = ST_FIN;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          mul_a     = div_rem;
          mul_b     = alignment_q;
          mul_start = 1'b1;
          st_d      = ST_MUL3;
        end
      end
      ST_MUL3: begin
        if (mul_done) begin
          slide_d = slide_base_q + mul_prod;
          st_d    = ST_FIN;
        end
      end
      ST_FIN: begin
        // hand off once the output register is free or being drained
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          st_d     = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      mix_q       <= MixerSeed;
      func_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      mix_q  <= mix_d;
      func_q <= func_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rand_q  <= rand_d;
    slide_q <= slide_d;
    if (out_load) begin
      out_q.random_value <= rand_q;
      out_q.slide        <= slide_q;
    end
  end

  // config writes; unknown index is dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slide_base_q <= '0;
      slot_count_q <= '0;
      alignment_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_addr_i)
        CFG_SLIDE_BASE: slide_base_q <= cfg_data_i;
        CFG_SLOT_COUNT: slot_count_q <= cfg_data_i;
        CFG_ALIGNMENT:  alignment_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // mixer only moves when a request is taken
  a_mix_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_acc |=> $stable(mix_q))
    else $error("mixer state changed without a request");

  // a degenerate slide skips all serial work
  a_degen_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.func && degen) |=> (st_q == ST_FIN) && $stable(mix_q))
    else $error("degenerate slide did not bypass the mixer");

  // multiplier completions only land in a multiply state
  a_mul_done_st: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (st_q == ST_MUL1 || st_q == ST_MUL2 || st_q == ST_MUL3))
    else $error("multiplier done outside a multiply state");

  // a new result appears only from the hand-off state
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(st_q == ST_FIN))
    else $error("output loaded outside hand-off");
`endif

endmodule

`default_nettype wire

// ===== hdl/ems_mul.sv =====
`default_nettype none

// Bit-serial shift-add multiplier, low word only. One multiplier bit per cycle.
module ems_mul (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [ems_pkg::DataW-1:0] a_i,
  input  logic [ems_pkg::DataW-1:0] b_i,
  output logic                      done_o,
  output logic [ems_pkg::DataW-1:0] prod_o
);
  import ems_pkg::*;

  logic             busy_q, done_q;
  logic [CntW-1:0]  cnt_q;
  logic [DataW-1:0] a_q, b_q, acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= {a_q[DataW-2:0], 1'b0};
      b_q <= {1'b0, b_q[DataW-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

`default_nettype wire

// ===== hdl/ems_div.sv =====
`default_nettype none

// Restoring remainder unit, one dividend bit per cycle. Divisor must be nonzero.
module ems_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [ems_pkg::DataW-1:0] dvd_i,
  input  logic [ems_pkg::DataW-1:0] dvs_i,
  output logic                      done_o,
  output logic [ems_pkg::DataW-1:0] rem_o
);
  import ems_pkg::*;

  logic             busy_q, done_q;
  logic [CntW-1:0]  cnt_q;
  logic [DataW-1:0] dvd_q, dvs_q, rem_q;
  logic [DataW:0]   trial;
  logic [DataW+1:0] diff;

  assign trial = {rem_q, dvd_q[DataW-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dvd_i;
      dvs_q <= dvs_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DataW-2:0], 1'b0};
      // no borrow: trial >= divisor
      if (!diff[DataW+1]) begin
        rem_q <= diff[DataW-1:0];
      end else begin
        rem_q <= trial[DataW-1:0];
      end
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// ===== dv/entropy_mixed_slide_generator_test.sv =====
// Self-checking bench for the entropy-mixed slide generator.
// The bench carries its own splitmix64 slide predictor, fed at each input
// transfer. Results are checked in order against the queue of predicted
// results. Both handshake sides idle at random, and one long output
// hold-off backs the block up so that the input stalls.
module entropy_mixed_slide_generator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ems_pkg::*;

  // Request kinds carried in the func bit
  localparam logic FuncRaw   = 1'b0;
  localparam logic FuncSlide = 1'b1;

  // Register index with no register behind it; writes must be dropped
  localparam logic [CfgAddrW-1:0] CfgUnmapped = 2'd3;

  localparam int unsigned SettleCycles  = 400;   // longer than the slowest request
  localparam int unsigned HoldOffCycles = 800;   // long output back-pressure
  localparam int unsigned HoldOffAfter  = 60;    // results seen before the hold-off
  localparam int unsigned WatchdogLimit = 8000;  // cycles with no transfer at all
  localparam int unsigned RandomPhases  = 8;
  localparam int unsigned PhaseItems    = 160;

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  ems_in_t             in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  ems_out_t            out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgAddrW-1:0] cfg_addr  = '0;
  logic [DataW-1:0]    cfg_data  = '0;

  entropy_mixed_slide_generator u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_addr_i  (cfg_addr),
    .cfg_data_i  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: bench-side copy of the mixer and the three registers
  // ---------------------------------------------------------------------------
  logic [DataW-1:0] mixer     = MixerSeed;
  logic [DataW-1:0] base_slide = '0;  // slide base
  logic [DataW-1:0] slot_count = '0;  // number of slots
  logic [DataW-1:0] slot_size  = '0;  // alignment

  ems_in_t  request_q[$];        // pending requests, drained by the driver
  ems_out_t slide_results_q[$];  // predicted results, oldest first

  logic in_xfer = 1'b0;  // input transfer seen at the last rising edge
  bit   idle_on = 1'b0;  // random idling allowed on both sides

  int unsigned gap_left        = 0;
  int unsigned stall_left      = 0;
  int unsigned hold_left       = 0;
  bit          hold_done       = 1'b0;
  int unsigned quiet_cycles    = 0;
  int unsigned fail_count      = 0;
  int unsigned results_checked = 0;
  int unsigned raw_seen        = 0;
  int unsigned slide_seen      = 0;
  int unsigned degenerate_seen = 0;
  int unsigned reg_writes      = 0;
  int unsigned settings_seen   = 0;

  // One splitmix64 request. A degenerate slide (no slots or zero slot size)
  // neither touches the mixer nor mixes in the timestamp.
  function automatic ems_out_t compute_slide_result(ems_in_t req);
    ems_out_t res;
    logic [DataW-1:0] z;
    res = '0;
    if (req.func == FuncSlide && (slot_size == '0 || slot_count == '0)) begin
      res.slide = base_slide;
      return res;
    end
    mixer = mixer ^ req.timestamp;
    if (req.hw_random_ok) begin
      mixer = mixer ^ req.hw_random;
    end
    mixer = mixer + GoldenGamma;
    z = mixer;
    z = (z ^ (z >> ShiftA)) * MixMulA;
    z = (z ^ (z >> ShiftB)) * MixMulB;
    z = z ^ (z >> ShiftC);
    res.random_value = z;
    if (req.func == FuncSlide) begin
      // product and sum both wrap at 64 bits
      res.slide = base_slide + (z % slot_count) * slot_size;
    end
    return res;
  endfunction

  // Random 64-bit word biased toward the corner values
  function automatic logic [DataW-1:0] rand_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 64'd1;
      3: return 64'd1 << $urandom_range(0, 63);
      4: return 64'($urandom_range(2, 1000));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic queue_req(logic func, logic [DataW-1:0] stamp, logic [DataW-1:0] hw,
                           logic hw_ok);
    ems_in_t req;
    req.func         = func;
    req.timestamp    = stamp;
    req.hw_random    = hw;
    req.hw_random_ok = hw_ok;
    request_q.push_back(req);
  endtask

  // Config transfer; only called while the block is idle
  task automatic write_reg(logic [CfgAddrW-1:0] addr, logic [DataW-1:0] value);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_addr  <= addr;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    case (addr)
      CFG_SLIDE_BASE: base_slide = value;
      CFG_SLOT_COUNT: slot_count = value;
      CFG_ALIGNMENT:  slot_size  = value;
      default: ;  // unmapped index: dropped
    endcase
    reg_writes++;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Wait for every request to be sent and answered, then let the block settle
  task automatic wait_drained();
    while (request_q.size() != 0 || in_valid || slide_results_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic check_field(string label, logic [DataW-1:0] want, logic [DataW-1:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, label, want, got);
      fail_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin : clock_gen
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Request driver: falling edge. A held request keeps valid and payload
  // until its transfer; otherwise it may idle or offer the next request.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : request_driver
    if (rst_ni && !(in_valid && !in_xfer)) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        in_valid <= 1'b0;
        gap_left = $urandom_range(0, 12);
      end else if (request_q.size() != 0) begin
        in_valid <= 1'b1;
        in_data  <= request_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output stall: random bursts, plus one long hold-off once traffic is up so
  // the finished result sits in the output register and the input backs up.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : result_stall
    if (rst_ni) begin
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (!hold_done && results_checked >= HoldOffAfter) begin
        hold_done = 1'b1;
        hold_left = HoldOffCycles - 1;
        out_stall <= 1'b1;
      end else if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 12);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: rising edge. Input transfers feed the predictor, output transfers
  // are checked against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    ems_out_t want;
    in_xfer <= rst_ni && in_valid && !in_stall;
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        if (in_data.func == FuncRaw) begin
          raw_seen++;
        end else if (slot_size == '0 || slot_count == '0) begin
          degenerate_seen++;
        end else begin
          slide_seen++;
        end
        slide_results_q.push_back(compute_slide_result(in_data));
      end
      if (out_valid && !out_stall) begin
        if (slide_results_q.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, got %h / %h",
                   $time, out_data.random_value, out_data.slide);
          fail_count++;
        end else begin
          want = slide_results_q.pop_front();
          check_field("random_value", want.random_value, out_data.random_value);
          check_field("slide", want.slide, out_data.slide);
          results_checked++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: any transfer on any channel resets the count
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t ns: no transfer for %0d cycles, %0d results outstanding",
                 $time, quiet_cycles, slide_results_q.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic func;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset config: all zero, so every slide is degenerate
    settings_seen++;
    queue_req(FuncRaw, '0, '0, 1'b0);
    queue_req(FuncRaw, '1, '1, 1'b1);
    queue_req(FuncRaw, '0, '1, 1'b0);                    // hw word not valid: ignored
    queue_req(FuncRaw, {32{2'b01}}, {32{2'b10}}, 1'b1);
    queue_req(FuncSlide, '1, '1, 1'b1);                  // degenerate: state untouched
    queue_req(FuncRaw, '0, '0, 1'b0);
    wait_drained();

    // No slots, nonzero slot size
    write_reg(CFG_SLIDE_BASE, '1);
    write_reg(CFG_ALIGNMENT, 64'd1);
    settings_seen++;
    queue_req(FuncSlide, 64'h0123_4567_89ab_cdef, '0, 1'b0);
    queue_req(FuncRaw, 64'd7, 64'd9, 1'b1);
    wait_drained();

    // Slots but zero slot size
    write_reg(CFG_SLOT_COUNT, 64'd5);
    write_reg(CFG_ALIGNMENT, '0);
    settings_seen++;
    queue_req(FuncSlide, '1, '0, 1'b1);
    wait_drained();

    // One slot of maximum size: slide is always the base
    write_reg(CFG_SLOT_COUNT, 64'd1);
    write_reg(CFG_ALIGNMENT, '1);
    settings_seen++;
    queue_req(FuncSlide, 64'd1, 64'd2, 1'b1);
    queue_req(FuncRaw, 64'd3, '1, 1'b0);
    wait_drained();

    // Maximum slot count and size: product and sum wrap
    write_reg(CFG_SLOT_COUNT, '1);
    settings_seen++;
    queue_req(FuncSlide, '1, '1, 1'b0);
    queue_req(FuncSlide, '0, 64'h8000_0000_0000_0000, 1'b1);
    wait_drained();

    // Top-bit slot count, step of two
    write_reg(CFG_SLIDE_BASE, 64'd1);
    write_reg(CFG_SLOT_COUNT, 64'h8000_0000_0000_0000);
    write_reg(CFG_ALIGNMENT, 64'd2);
    settings_seen++;
    queue_req(FuncSlide, 64'h8000_0000_0000_0001, '0, 1'b0);
    queue_req(FuncSlide, 64'd42, 64'h1, 1'b1);
    wait_drained();

    // Unmapped index must leave every register alone
    write_reg(CfgUnmapped, '1);
    write_reg(CFG_SLIDE_BASE, '0);
    write_reg(CFG_SLOT_COUNT, 64'd3);
    write_reg(CFG_ALIGNMENT, 64'd16);
    settings_seen++;
    queue_req(FuncSlide, 64'd100, 64'd200, 1'b1);
    queue_req(FuncSlide, 64'd101, 64'd201, 1'b0);
    queue_req(FuncRaw, 64'd102, 64'd202, 1'b1);
    wait_drained();

    // Random phases: fresh register values, then a run of random requests.
    // The last phase runs with no idling on either side.
    for (int p = 0; p < RandomPhases; p++) begin
      write_reg(CFG_SLIDE_BASE, rand_word());
      write_reg(CFG_SLOT_COUNT, rand_word());
      write_reg(CFG_ALIGNMENT, rand_word());
      if ($urandom_range(0, 3) == 0) begin
        write_reg(CfgUnmapped, rand_word());
      end
      settings_seen++;
      idle_on = (p != RandomPhases - 1) && ($urandom_range(0, 3) != 0);
      for (int i = 0; i < PhaseItems; i++) begin
        func = 1'($urandom_range(0, 1));
        queue_req(func, rand_word(), rand_word(), 1'($urandom_range(0, 1)));
      end
      wait_drained();
    end

    if (slide_results_q.size() != 0) begin
      $display("%0t ns: %0d results never arrived", $time, slide_results_q.size());
      fail_count++;
    end

    $display("Covered %0d raw, %0d slide and %0d degenerate slide requests, %0d checked.",
             raw_seen, slide_seen, degenerate_seen, results_checked);
    $display("%0d register writes over %0d settings, one long output hold-off, %0d errors.",
             reg_writes, settings_seen, fail_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
